>>> rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// Polar / Cartesian converter package
// Shared widths, constants, the CORDIC word type and the stage angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

    // Micro-rotation count and fixed-point formats.
    localparam int CORDIC_STAGES = 16;
    localparam int FRACTION_BITS = 16;
    localparam int GUARD         = 24;
    localparam int WORD_W        = 32;
    localparam int ANGLE_IN_W    = 26;
    localparam int ANGLE_FRAC    = 32;

    // Stream word widths, padded to whole bytes.
    localparam int TDATA_IN_W  = ((WORD_W + ANGLE_IN_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((2 * WORD_W + 7) / 8) * 8;

    // Internal widths: coordinates carry guard bits and headroom for the gain,
    // angles hold up to about 512 degrees with 32 fraction bits.
    localparam int COORD_W = WORD_W + GUARD + 3;
    localparam int ANGLE_W = ANGLE_FRAC + 10;
    localparam int RED_W   = ANGLE_IN_W + 1;
    localparam int SHIFT_W = $clog2(CORDIC_STAGES);
    localparam int WIDE_W  = WORD_W + 5;

    // Inverse of the CORDIC limit gain with 32 fraction bits.
    localparam logic [WORD_W-1:0] INV_GAIN   = 32'h9B74EDA8;
    // 180/pi with 26 fraction bits, used to build the angle table.
    localparam logic [63:0]       RAD_TO_DEG = 64'd3845054675;

    // Action codes carried in tuser.
    localparam logic ACT_TO_CART  = 1'b0;
    localparam logic ACT_TO_POLAR = 1'b1;

    // Turn constants in the input angle format.
    localparam logic signed [RED_W-1:0] FULL_IN    = RED_W'(360) <<< FRACTION_BITS;
    localparam logic signed [RED_W-1:0] HALF_IN    = RED_W'(180) <<< FRACTION_BITS;
    localparam logic signed [RED_W-1:0] QUARTER_IN = RED_W'(90) <<< FRACTION_BITS;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    // Turn constants in the internal angle format.
    localparam angle_t HALF_Z    = angle_t'(180) <<< ANGLE_FRAC;
    localparam angle_t QUARTER_Z = angle_t'(90) <<< ANGLE_FRAC;

    // Saturation bounds.
    localparam logic [WORD_W-1:0] SAT_HI = {1'b0, {(WORD_W - 1){1'b1}}};
    localparam logic [WORD_W-1:0] SAT_LO = {1'b1, {(WORD_W - 1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] WIDE_MAX =
        (WIDE_W'(1) <<< (WORD_W - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = -(WIDE_W'(1) <<< (WORD_W - 1));

    // One CORDIC word as it travels along the chain of cells.
    typedef struct packed {
        logic   vec;
        logic   flip;
        logic   zero;
        coord_t x;
        coord_t y;
        angle_t z;
    } cordic_t;

    // Division of a series term by the odd number 2k+1.
    function automatic logic [63:0] odd_div(input logic [63:0] p, input int unsigned k);
        logic [63:0] q;
        case (k)
            0:  q = p;
            1:  q = p / 64'd3;
            2:  q = p / 64'd5;
            3:  q = p / 64'd7;
            4:  q = p / 64'd9;
            5:  q = p / 64'd11;
            6:  q = p / 64'd13;
            7:  q = p / 64'd15;
            8:  q = p / 64'd17;
            9:  q = p / 64'd19;
            10: q = p / 64'd21;
            11: q = p / 64'd23;
            12: q = p / 64'd25;
            13: q = p / 64'd27;
            14: q = p / 64'd29;
            15: q = p / 64'd31;
            16: q = p / 64'd33;
            17: q = p / 64'd35;
            18: q = p / 64'd37;
            19: q = p / 64'd39;
            20: q = p / 64'd41;
            21: q = p / 64'd43;
            22: q = p / 64'd45;
            23: q = p / 64'd47;
            24: q = p / 64'd49;
            25: q = p / 64'd51;
            26: q = p / 64'd53;
            27: q = p / 64'd55;
            28: q = p / 64'd57;
            29: q = p / 64'd59;
            30: q = p / 64'd61;
            31: q = p / 64'd63;
            default: q = p;
        endcase
        return q;
    endfunction

    // atan(2^-idx) in degrees with 32 fraction bits, from the arctangent series.
    function automatic logic [ANGLE_W-1:0] stage_angle(input int unsigned idx);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] acc;
        logic [63:0] st;
        if (idx == 0)
        begin
            st = 64'd45 << 32;
        end
        else
        begin
            p   = 64'd1 << (60 - idx);
            sum = 64'd0;
            for (int k = 0; k < 32; k++)
            begin
                if (p != 64'd0)
                begin
                    if ((k & 1) != 0)
                        sum = sum - odd_div(p, k);
                    else
                        sum = sum + odd_div(p, k);
                    p = p >> (2 * idx);
                end
            end
            acc = (sum >> 32) * RAD_TO_DEG +
                  (((sum & 64'hFFFF_FFFF) * RAD_TO_DEG) >> 32);
            st  = (acc + (64'd1 << 21)) >> 22;
        end
        return st[ANGLE_W-1:0];
    endfunction

    // Clamp to the signed word range; the top bit of the result is the overflow flag.
    function automatic logic [WORD_W:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic [WORD_W:0] r;
        if (v > WIDE_MAX)
            r = {1'b1, SAT_HI};
        else if (v < WIDE_MIN)
            r = {1'b1, SAT_LO};
        else
            r = {1'b0, v[WORD_W-1:0]};
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pcc_pre.sv
// ----------------------------------------------------------------------------
// Polar / Cartesian converter input conditioning
// Angle reduction, quadrant fold and gain compensation ahead of the CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_pre (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           in_action,
    input  wire logic signed [pcc_pkg::WORD_W-1:0]     in_x,
    input  wire logic signed [pcc_pkg::ANGLE_IN_W-1:0] in_y,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output pcc_pkg::cordic_t                    out_data
);
    import pcc_pkg::*;

    typedef struct packed {
        logic                      vec;
        logic                      flip;
        logic                      neg;
        logic                      zero;
        logic signed [WORD_W:0]    mag;
        logic signed [RED_W-1:0]   py;
        angle_t                    z;
    } pre1_t;

    pre1_t                  s1_reg;
    pre1_t                  s1_next;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_ready;
    pre1_t                  s2_reg;
    logic [2*WORD_W-1:0]    prod_reg;
    logic [2*WORD_W-1:0]    prod_next;
    logic                   s2_valid_reg;
    logic                   s2_valid_next;
    logic                   s2_ready;

    logic signed [RED_W-1:0] t0;
    logic signed [RED_W-1:0] t1;
    logic signed [RED_W-1:0] t2;
    logic signed [RED_W-1:0] t3;
    logic                    fold;
    logic                    x_neg;
    coord_t                  gain_x;
    coord_t                  cart_x;
    coord_t                  polar_x;
    coord_t                  polar_y;

    // Handshake between the two register stages.
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s2_ready = !s2_valid_reg || out_ready;
    assign in_ready = s1_ready;

    // Angle reduction into -180..180, then fold into -90..90.
    always_comb
    begin
        t0 = RED_W'(in_y);
        if (t0 >= FULL_IN)
            t1 = t0 - FULL_IN;
        else if (t0 <= -FULL_IN)
            t1 = t0 + FULL_IN;
        else
            t1 = t0;

        if (t1 > HALF_IN)
            t2 = t1 - FULL_IN;
        else if (t1 < -HALF_IN)
            t2 = t1 + FULL_IN;
        else
            t2 = t1;

        fold = 1'b0;
        if (t2 > QUARTER_IN)
        begin
            t3   = t2 - HALF_IN;
            fold = 1'b1;
        end
        else if (t2 < -QUARTER_IN)
        begin
            t3   = t2 + HALF_IN;
            fold = 1'b1;
        end
        else
        begin
            t3 = t2;
        end
    end

    // First stage word: magnitude of x or radius, folded y and start angle.
    always_comb
    begin
        x_neg        = in_x[WORD_W-1];
        s1_next.vec  = (in_action == ACT_TO_POLAR);
        s1_next.neg  = x_neg;
        s1_next.mag  = x_neg ? -((WORD_W + 1)'(in_x)) : (WORD_W + 1)'(in_x);
        s1_next.zero = (in_action == ACT_TO_POLAR) && (in_x == '0) && (in_y == '0);
        if (in_action == ACT_TO_POLAR)
        begin
            s1_next.flip = 1'b0;
            s1_next.py   = x_neg ? -(RED_W'(in_y)) : RED_W'(in_y);
            if (!x_neg)
                s1_next.z = '0;
            else if (!in_y[ANGLE_IN_W-1])
                s1_next.z = HALF_Z;
            else
                s1_next.z = -HALF_Z;
        end
        else
        begin
            s1_next.flip = fold;
            s1_next.py   = '0;
            s1_next.z    = angle_t'(t3) <<< (ANGLE_FRAC - FRACTION_BITS);
        end
    end

    // Gain compensation product for the rotation path.
    assign prod_next = (2 * WORD_W)'(s1_reg.mag[WORD_W-1:0]) * (2 * WORD_W)'(INV_GAIN);

    always_comb
    begin
        s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg   <= s1_reg;
            prod_reg <= prod_next;
        end
    end

    // Start vector for the first cell.
    always_comb
    begin
        gain_x  = coord_t'(prod_reg >> (WORD_W - GUARD));
        cart_x  = s2_reg.neg ? -gain_x : gain_x;
        polar_x = coord_t'(s2_reg.mag) <<< GUARD;
        polar_y = coord_t'(s2_reg.py) <<< GUARD;

        out_data.vec  = s2_reg.vec;
        out_data.flip = s2_reg.flip;
        out_data.zero = s2_reg.zero;
        out_data.x    = s2_reg.vec ? polar_x : cart_x;
        out_data.y    = s2_reg.vec ? polar_y : '0;
        out_data.z    = s2_reg.z;
    end

    assign out_valid = s2_valid_reg;

`ifndef ASSERT_OFF
    // The folded rotation angle never leaves a quarter turn.
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_reg.vec |-> (s1_reg.z <= QUARTER_Z) && (s1_reg.z >= -QUARTER_Z))
        else $error("rotation angle outside a quarter turn after fold");

    // Only the vectoring path knows a zero vector, and it never folds.
    a_zero_mode: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (s1_reg.zero || s1_reg.flip) |-> (s1_reg.vec == s1_reg.zero))
        else $error("zero or fold flag in the wrong mode");
`endif

endmodule

`default_nettype wire

>>> rtl/pcc_cell.sv
// ----------------------------------------------------------------------------
// Polar / Cartesian converter CORDIC cell
// One registered micro-rotation, in rotation or vectoring mode.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire pcc_pkg::cordic_t             in_data,
    input  wire logic [pcc_pkg::SHIFT_W-1:0]  shift,
    input  wire pcc_pkg::angle_t              angle,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output pcc_pkg::cordic_t                  out_data
);
    import pcc_pkg::*;

    cordic_t data_reg;
    cordic_t data_next;
    logic    valid_reg;
    logic    valid_next;
    coord_t  xi;
    coord_t  yi;
    angle_t  zi;
    coord_t  dx;
    coord_t  dy;
    logic    ccw;

    assign in_ready = !valid_reg || out_ready;

    // Rotation steers on the residual angle, vectoring on the sign of y.
    always_comb
    begin
        xi  = in_data.x;
        yi  = in_data.y;
        zi  = in_data.z;
        dx  = yi >>> shift;
        dy  = xi >>> shift;
        ccw = in_data.vec ? yi[COORD_W-1] : !zi[ANGLE_W-1];

        data_next = in_data;
        if (ccw)
        begin
            data_next.x = xi - dx;
            data_next.y = yi + dy;
            data_next.z = zi - angle;
        end
        else
        begin
            data_next.x = xi + dx;
            data_next.y = yi - dy;
            data_next.z = zi + angle;
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef ASSERT_OFF
    // In vectoring mode every micro-rotation moves x away from the y axis.
    a_vec_grow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.vec |=> $signed(out_data.x) >= $signed($past(xi)))
        else $error("vectoring step reduced x");
`endif

endmodule

`default_nettype wire

>>> rtl/pcc_post.sv
// ----------------------------------------------------------------------------
// Polar / Cartesian converter output stage
// Gain compensation of the radius, rounding, saturation and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_post (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire pcc_pkg::cordic_t           in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [pcc_pkg::WORD_W-1:0]      out_x,
    output logic [pcc_pkg::WORD_W-1:0]      out_y,
    output logic                            out_ov
);
    import pcc_pkg::*;

    typedef struct packed {
        logic                     vec;
        logic                     zero;
        logic signed [WIDE_W-1:0] ax;
        logic signed [WIDE_W-1:0] ay;
        logic [COORD_W-1:0]       hi;
        logic [WORD_W-1:0]        lo;
    } post_a_t;

    post_a_t                a_reg;
    post_a_t                a_next;
    logic                   a_valid_reg;
    logic                   a_valid_next;
    logic                   a_ready;
    logic                   b_ready;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [WORD_W-1:0]      out_x_reg;
    logic [WORD_W-1:0]      out_x_next;
    logic [WORD_W-1:0]      out_y_reg;
    logic [WORD_W-1:0]      out_y_next;
    logic                   out_ov_reg;
    logic                   out_ov_next;

    coord_t                   xi;
    coord_t                   yi;
    angle_t                   zi;
    angle_t                   zc;
    angle_t                   zr;
    coord_t                   xr;
    coord_t                   yr;
    logic signed [WIDE_W-1:0] rx;
    logic signed [WIDE_W-1:0] ry;
    logic [COORD_W-1:0]       xpos;
    logic [2*WORD_W-1:0]      lo_full;
    logic [COORD_W:0]         m_sum;
    logic [COORD_W:0]         m_rnd;
    logic signed [WIDE_W-1:0] rad;
    logic signed [WIDE_W-1:0] vx;
    logic [WORD_W:0]          sx;
    logic [WORD_W:0]          sy;

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !out_valid_reg || out_ready;
    assign in_ready = a_ready;

    // Stage A: round the rotation results, clamp and round the angle, and
    // split the radius gain product into high and low halves.
    always_comb
    begin
        xi = in_data.x;
        yi = in_data.y;
        zi = in_data.z;

        xr = xi + (coord_t'(1) <<< (GUARD - 1));
        yr = yi + (coord_t'(1) <<< (GUARD - 1));
        rx = WIDE_W'(xr >>> GUARD);
        ry = WIDE_W'(yr >>> GUARD);

        if (zi > HALF_Z)
            zc = HALF_Z;
        else if (zi < -HALF_Z)
            zc = -HALF_Z;
        else
            zc = zi;
        zr = zc + (angle_t'(1) <<< (ANGLE_FRAC - FRACTION_BITS - 1));

        xpos    = xi[COORD_W-1] ? '0 : xi;
        lo_full = (2 * WORD_W)'(xpos[WORD_W-1:0]) * (2 * WORD_W)'(INV_GAIN);

        a_next.vec  = in_data.vec;
        a_next.zero = in_data.zero;
        a_next.hi   = COORD_W'(xpos[COORD_W-1:WORD_W]) * COORD_W'(INV_GAIN);
        a_next.lo   = lo_full[2*WORD_W-1:WORD_W];
        if (in_data.vec)
        begin
            a_next.ax = '0;
            a_next.ay = WIDE_W'(zr >>> (ANGLE_FRAC - FRACTION_BITS));
        end
        else
        begin
            a_next.ax = in_data.flip ? -rx : rx;
            a_next.ay = in_data.flip ? -ry : ry;
        end
    end

    // Stage B: finish the radius, saturate both results.
    always_comb
    begin
        m_sum = (COORD_W + 1)'(a_reg.hi) + (COORD_W + 1)'(a_reg.lo);
        m_rnd = m_sum + ((COORD_W + 1)'(1) << (GUARD - 1));
        rad   = WIDE_W'(m_rnd >> GUARD);
        vx    = a_reg.vec ? rad : a_reg.ax;
        sx    = sat_word(vx);
        sy    = sat_word(a_reg.ay);
        if (a_reg.zero)
        begin
            out_x_next  = '0;
            out_y_next  = '0;
            out_ov_next = 1'b0;
        end
        else
        begin
            out_x_next  = sx[WORD_W-1:0];
            out_y_next  = sy[WORD_W-1:0];
            out_ov_next = sx[WORD_W] | sy[WORD_W];
        end
    end

    always_comb
    begin
        a_valid_next   = a_ready ? in_valid : a_valid_reg;
        out_valid_next = b_ready ? a_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_reg <= a_next;
        end
        if (b_ready && a_valid_reg)
        begin
            out_x_reg  <= out_x_next;
            out_y_reg  <= out_y_next;
            out_ov_reg <= out_ov_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_ov    = out_ov_reg;

`ifndef ASSERT_OFF
    // A raised overflow flag always comes with a clamped result.
    a_ov_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ov_reg |->
            (out_x_reg == SAT_HI) || (out_x_reg == SAT_LO) ||
            (out_y_reg == SAT_HI) || (out_y_reg == SAT_LO))
        else $error("overflow flag without a saturated result");

    // A zero vector from stage A leaves as all zeros.
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && b_ready && a_reg.zero |=>
            (out_x_reg == '0) && (out_y_reg == '0) && !out_ov_reg)
        else $error("zero vector produced a nonzero result");
`endif

endmodule

`default_nettype wire

>>> rtl/polar_cartesian_converter_top.sv
// ----------------------------------------------------------------------------
// Polar / Cartesian converter
// Pipelined CORDIC that turns polar points into Cartesian ones and back.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata (low bit up)                      tuser
//  s_axis    in         coord_x_or_radius[31:0],                action
//                       coord_y_or_angle[57:32], zero pad
//  m_axis    out        result_x_or_radius[31:0],               overflow_flag
//                       result_y_or_angle[63:32]
//
//  One word is accepted per cycle unless the pipeline is full behind a stalled
//  output; the path holds two conditioning stages, one register per cell and
//  two output stages.
//  Reset clears every valid bit; the data registers keep their contents.
//  A stalled output holds its word while upstream stages keep filling empty
//  slots, so input is refused only once every stage holds a word.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_cartesian_converter_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // coord_x_or_radius [31:0], coord_y_or_angle [57:32], zeros above
    input  wire logic [pcc_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
    // action
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // result_x_or_radius [31:0], result_y_or_angle [63:32]
    output logic [pcc_pkg::TDATA_OUT_W-1:0]          m_axis_tdata,
    // overflow_flag
    output logic                                     m_axis_tuser
);
    import pcc_pkg::*;

    cordic_t                 chain_data [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0]  chain_valid;
    logic [CORDIC_STAGES:0]  chain_ready;
    logic [WORD_W-1:0]       res_x;
    logic [WORD_W-1:0]       res_y;

    // Input conditioning feeds the head of the chain.
    pcc_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_x      (s_axis_tdata[WORD_W-1:0]),
        .in_y      (s_axis_tdata[WORD_W+ANGLE_IN_W-1:WORD_W]),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // Chain of micro-rotation cells, each with its own shift and table angle.
    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        localparam angle_t STAGE_ANGLE = angle_t'(stage_angle(g));

        pcc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .shift     (SHIFT_W'(g)),
            .angle     (STAGE_ANGLE),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    // Rounding, radius gain and saturation ahead of the result register.
    pcc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[CORDIC_STAGES]),
        .in_ready  (chain_ready[CORDIC_STAGES]),
        .in_data   (chain_data[CORDIC_STAGES]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_x     (res_x),
        .out_y     (res_y),
        .out_ov    (m_axis_tuser)
    );

    assign m_axis_tdata = TDATA_OUT_W'({res_y, res_x});

`ifndef ASSERT_OFF
    // Input is refused only when the whole pipeline is full behind a stalled output.
    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused while the pipeline still has room");

    // A word at the tail of the chain moves on whenever the output is free.
    a_tail_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> chain_ready[CORDIC_STAGES])
        else $error("chain tail stalled with an empty output");
`endif

endmodule

`default_nettype wire
